// ===== sv/dptc_pkg.sv =====
// ============================================================================
// Decision point token counter package
// Shared widths, character constants, item types and the internal token type.
// ============================================================================
`default_nettype none

package dptc_pkg;

    // Width of the hit counters and of the result fields.
    localparam int CountWidth   = 32;
    localparam int OutWidth     = 32;

    // Window of recent bytes in the current line, newest first.
    localparam int RecentDepth  = 6;
    localparam int LineCntWidth = 3;

    // Queue between the classifier and the scanner (power of two).
    localparam int QueueDepth   = 4;
    localparam int QueueAw      = $clog2(QueueDepth);

    // Command codes.
    localparam logic CmdChar = 1'b0;
    localparam logic CmdEnd  = 1'b1;

    // Characters of interest.
    localparam logic [7:0] ChNewline = 8'h0A;
    localparam logic [7:0] ChQmark   = 8'h3F;
    localparam logic [7:0] ChAmp     = 8'h26;
    localparam logic [7:0] ChBar     = 8'h7C;
    localparam logic [7:0] ChSlash   = 8'h2F;
    localparam logic [7:0] ChStar    = 8'h2A;

    typedef enum logic [1:0] {
        PAIR_NONE,
        PAIR_AMP,
        PAIR_BAR
    } t_pair;

    typedef struct packed {
        logic       command;
        logic [7:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic [OutWidth-1:0] point_count;
        logic [OutWidth-1:0] complexity;
    } t_out_item;

    // A classified beat as it travels through the queue.
    typedef struct packed {
        logic       is_end;
        logic [7:0] code;
        logic       is_word;
        logic       is_qmark;
        logic       is_amp;
        logic       is_bar;
        logic       is_slash;
        logic       is_star;
        logic       is_newline;
    } t_token;

endpackage

`default_nettype wire

// ===== sv/dptc_front.sv =====
// ============================================================================
// Decision point token counter front end
// Accepts input beats and registers them as classified tokens.
// ============================================================================
`default_nettype none

module dptc_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire dptc_pkg::t_in_item i_in_data,
    output logic                   o_in_ready,
    output logic                   o_tok_valid,
    output dptc_pkg::t_token       o_tok,
    input  wire logic              i_tok_ready
);

    logic             r_valid;
    dptc_pkg::t_token r_tok;
    dptc_pkg::t_token n_tok;
    logic             accept;

    always_comb begin
        n_tok.is_end     = (i_in_data.command == dptc_pkg::CmdEnd);
        n_tok.code       = i_in_data.char_code;
        n_tok.is_word    = (i_in_data.char_code >= "0" && i_in_data.char_code <= "9") ||
                           (i_in_data.char_code >= "A" && i_in_data.char_code <= "Z") ||
                           (i_in_data.char_code >= "a" && i_in_data.char_code <= "z");
        n_tok.is_qmark   = (i_in_data.char_code == dptc_pkg::ChQmark);
        n_tok.is_amp     = (i_in_data.char_code == dptc_pkg::ChAmp);
        n_tok.is_bar     = (i_in_data.char_code == dptc_pkg::ChBar);
        n_tok.is_slash   = (i_in_data.char_code == dptc_pkg::ChSlash);
        n_tok.is_star    = (i_in_data.char_code == dptc_pkg::ChStar);
        n_tok.is_newline = (i_in_data.char_code == dptc_pkg::ChNewline);
    end

    // The stage refills in the same cycle that it drains into the queue.
    assign o_in_ready  = !r_valid || i_tok_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_tok_valid = r_valid;
    assign o_tok       = r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_tok_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tok <= n_tok;
        end
    end

endmodule

`default_nettype wire

// ===== sv/dptc_queue.sv =====
// ============================================================================
// Decision point token counter queue
// Small register queue of classified tokens between front end and scanner.
// ============================================================================
`default_nettype none

module dptc_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire dptc_pkg::t_token i_push_data,
    output logic                  o_ready,
    output logic                  o_valid,
    output dptc_pkg::t_token      o_data,
    input  wire logic             i_pop
);

    dptc_pkg::t_token                 r_mem [dptc_pkg::QueueDepth];
    logic [dptc_pkg::QueueAw-1:0]     r_wr_ptr;
    logic [dptc_pkg::QueueAw-1:0]     r_rd_ptr;
    logic [dptc_pkg::QueueAw:0]       r_count;
    logic                             do_push;
    logic                             do_pop;

    assign o_ready = (r_count != (dptc_pkg::QueueAw+1)'(dptc_pkg::QueueDepth));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/dptc_back.sv =====
// ============================================================================
// Decision point token counter scanner
// Runs the per-line scan, commits line hits and registers the result beat.
// ============================================================================
`default_nettype none

module dptc_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_tok_valid,
    input  wire dptc_pkg::t_token   i_tok,
    output logic                    o_pop,
    output logic                    o_out_valid,
    output dptc_pkg::t_out_item     o_out_data,
    input  wire logic               i_out_ready
);

    localparam int Cw = dptc_pkg::CountWidth;
    localparam int Ow = dptc_pkg::OutWidth;
    localparam int Rd = dptc_pkg::RecentDepth;
    localparam int Lw = dptc_pkg::LineCntWidth;

    function automatic logic [Cw-1:0] sat_add(input logic [Cw-1:0] a,
                                              input logic [Cw-1:0] b);
        logic [Cw:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[Cw] ? '1 : s[Cw-1:0];
    endfunction

    function automatic logic [Ow-1:0] clip_out(input logic [Cw-1:0] v);
        logic [Cw+Ow-1:0] wide;
        wide = (Cw+Ow)'(v);
        return (wide[Cw+Ow-1:Ow] != '0) ? '1 : wide[Ow-1:0];
    endfunction

    // Line and comment state.
    logic                  r_inside,  n_inside;
    logic [Cw-1:0]         r_total,   n_total;
    logic [Cw-1:0]         r_line,    n_line;
    logic                  r_open,    n_open;
    logic                  r_close,   n_close;
    logic                  r_cbo,     n_cbo;
    logic                  r_lcs,     n_lcs;
    logic [Lw-1:0]         r_cnt,     n_cnt;
    dptc_pkg::t_pair       r_pend,    n_pend;
    logic [7:0]            r_code [Rd];
    logic [7:0]            n_code [Rd];
    logic [Rd-1:0]         r_word,    n_word;

    // Result register.
    logic                  r_out_valid, n_out_valid;
    dptc_pkg::t_out_item   r_out,       n_out;

    logic                  word_hit;
    logic                  inside_eol;
    logic                  hit_word;
    logic                  hit_pair;
    logic [Cw-1:0]         line_inc;
    logic [Cw-1:0]         line_fin;
    logic [Cw-1:0]         total_fin;

    // A keyword ends at the newest byte when its letters match and the byte
    // before it is an edge or the start of the line.
    always_comb begin
        word_hit = 1'b0;
        if (r_cnt >= Lw'(2) && {r_code[1], r_code[0]} == "if" &&
            (r_cnt == Lw'(2) || !r_word[2])) begin
            word_hit = 1'b1;
        end
        if (r_cnt >= Lw'(3) && {r_code[2], r_code[1], r_code[0]} == "for" &&
            (r_cnt == Lw'(3) || !r_word[3])) begin
            word_hit = 1'b1;
        end
        if (r_cnt >= Lw'(4) &&
            {r_code[3], r_code[2], r_code[1], r_code[0]} == "case" &&
            (r_cnt == Lw'(4) || !r_word[4])) begin
            word_hit = 1'b1;
        end
        if (r_cnt >= Lw'(5) &&
            {r_code[4], r_code[3], r_code[2], r_code[1], r_code[0]} == "while" &&
            (r_cnt == Lw'(5) || !r_word[5])) begin
            word_hit = 1'b1;
        end
    end

    assign inside_eol = r_open ? !(r_close && !r_cbo) : (r_close ? 1'b0 : r_inside);
    assign o_pop      = i_tok_valid && (!i_tok.is_end || !r_out_valid || i_out_ready);

    always_comb begin
        n_inside    = r_inside;
        n_total     = r_total;
        n_line      = r_line;
        n_open      = r_open;
        n_close     = r_close;
        n_cbo       = r_cbo;
        n_lcs       = r_lcs;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_code      = r_code;
        n_word      = r_word;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        hit_word    = !r_lcs && word_hit && !i_tok.is_word;
        hit_pair    = 1'b0;
        line_inc    = r_line;
        line_fin    = r_line;
        total_fin   = r_total;

        if (o_pop && !i_tok.is_end) begin
            if (!r_lcs) begin
                if (i_tok.is_qmark) begin
                    hit_pair = 1'b1;
                    n_pend   = dptc_pkg::PAIR_NONE;
                end else if (i_tok.is_amp) begin
                    hit_pair = (r_pend == dptc_pkg::PAIR_AMP);
                    n_pend   = hit_pair ? dptc_pkg::PAIR_NONE : dptc_pkg::PAIR_AMP;
                end else if (i_tok.is_bar) begin
                    hit_pair = (r_pend == dptc_pkg::PAIR_BAR);
                    n_pend   = hit_pair ? dptc_pkg::PAIR_NONE : dptc_pkg::PAIR_BAR;
                end else begin
                    n_pend   = dptc_pkg::PAIR_NONE;
                end
            end
            line_inc = sat_add(r_line, Cw'({1'b0, hit_word} + {1'b0, hit_pair}));
            n_line   = line_inc;

            if (r_cnt != '0) begin
                if (r_code[0] == dptc_pkg::ChSlash && i_tok.is_slash) begin
                    n_lcs = 1'b1;
                end
                if (r_code[0] == dptc_pkg::ChSlash && i_tok.is_star) begin
                    n_open = 1'b1;
                end
                if (r_code[0] == dptc_pkg::ChStar && i_tok.is_slash && !r_close) begin
                    n_close = 1'b1;
                    n_cbo   = !r_open;
                end
            end

            for (int i = Rd - 1; i > 0; i--) begin
                n_code[i] = r_code[i-1];
                n_word[i] = r_word[i-1];
            end
            n_code[0] = i_tok.code;
            n_word[0] = i_tok.is_word;
            if (r_cnt != '1) begin
                n_cnt = r_cnt + 1'b1;
            end

            // Line end: settle the comment status and commit the line.
            if (i_tok.is_newline) begin
                n_inside = inside_eol;
                if (!inside_eol) begin
                    n_total = sat_add(r_total, line_inc);
                end
                n_line  = '0;
                n_open  = 1'b0;
                n_close = 1'b0;
                n_cbo   = 1'b0;
                n_lcs   = 1'b0;
                n_cnt   = '0;
                n_pend  = dptc_pkg::PAIR_NONE;
            end
        end else if (o_pop && i_tok.is_end) begin
            // An open line is closed as if an edge byte and a newline came.
            if (r_cnt != '0) begin
                line_fin = sat_add(r_line, Cw'(!r_lcs && word_hit));
                if (!inside_eol) begin
                    total_fin = sat_add(r_total, line_fin);
                end
            end
            n_out.point_count = clip_out(total_fin);
            n_out.complexity  = clip_out(sat_add(total_fin, Cw'(1)));
            n_out_valid = 1'b1;
            n_inside    = 1'b0;
            n_total     = '0;
            n_line      = '0;
            n_open      = 1'b0;
            n_close     = 1'b0;
            n_cbo       = 1'b0;
            n_lcs       = 1'b0;
            n_cnt       = '0;
            n_pend      = dptc_pkg::PAIR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside    <= 1'b0;
            r_total     <= '0;
            r_line      <= '0;
            r_open      <= 1'b0;
            r_close     <= 1'b0;
            r_cbo       <= 1'b0;
            r_lcs       <= 1'b0;
            r_cnt       <= '0;
            r_pend      <= dptc_pkg::PAIR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_inside    <= n_inside;
            r_total     <= n_total;
            r_line      <= n_line;
            r_open      <= n_open;
            r_close     <= n_close;
            r_cbo       <= n_cbo;
            r_lcs       <= n_lcs;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_word <= n_word;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== sv/decision_point_token_counter_core.sv =====
// ============================================================================
// Decision point token counter core
// Throughput: one beat per clock in either direction, unless an end beat waits
// on a held result and the queue fills. An end beat accepted into the
// classifier register enters the queue and from there loads the result
// register; the scanner settles each byte as it pops it from the queue.
// Reset: synchronous active low; clears all counts, the comment status and
// the queue, and leaves the result register empty.
// ============================================================================
`default_nettype none

module decision_point_token_counter_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire dptc_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output dptc_pkg::t_out_item      o_out_data
);

    // Front end to queue.
    logic             fr_valid;
    dptc_pkg::t_token fr_tok;
    logic             q_ready;

    // Queue to scanner.
    logic             q_valid;
    dptc_pkg::t_token q_tok;
    logic             q_pop;

    // The front end decodes each incoming byte into the handful of classes
    // the scanner cares about (word byte, question mark, ampersand, bar,
    // slash, star, newline) and holds it in one register stage.
    dptc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .o_tok_valid (fr_valid),
        .o_tok       (fr_tok),
        .i_tok_ready (q_ready)
    );

    // The queue lets the front end keep taking beats while the scanner waits
    // for a stalled result beat to drain.
    dptc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (fr_valid),
        .i_push_data (fr_tok),
        .o_ready     (q_ready),
        .o_valid     (q_valid),
        .o_data      (q_tok),
        .i_pop       (q_pop)
    );

    // The scanner keeps a short window of recent line bytes for keyword matching,
    // tracks the comment markers of the current line, and commits the line's hits
    // at each newline unless the line ends inside a comment. Source bytes never
    // wait on the output; only an end beat waits while an earlier result is held.
    dptc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (q_valid),
        .i_tok       (q_tok),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

    // An end beat leaving the queue always loads the result register.
    a_end_loads_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop && q_tok.is_end) |=> o_out_valid)
        else $error("end beat left the queue without producing a result");

    // A new result appears only as the consequence of an end beat.
    a_result_has_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(q_pop && q_tok.is_end))
        else $error("result beat appeared without an end beat");

    // Complexity is always one above the decision count unless saturated.
    a_complexity_rel : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_data.complexity == o_out_data.point_count + 32'd1) ||
            (o_out_data.complexity == '1 && o_out_data.point_count == '1))
        else $error("complexity does not match decision points");

endmodule

`default_nettype wire
